[rtl/core/lbp_pkg.sv]
// Package for the LSB-first bit packer: command and item codes, the queue
// item type and shared constants. No dependencies.
`default_nettype none

package lbp_pkg;

  // Default store size in bytes
  localparam int LBP_STORE_BYTES = 1024;

  // Depth of the queue between front and back
  localparam int LBP_QUEUE_DEPTH = 2;

  // Field widths fixed by the interface
  localparam int POS_W   = 14;
  localparam int COUNT_W = 6;
  localparam int BIDX_W  = 10;

  // Capacity after reset, in bits
  localparam logic [POS_W-1:0] CAPACITY_RESET = 14'd8192;

  // Maxima above this write a full 32-bit word as one unit
  localparam logic [31:0] FULL_WIDTH_BOUND = 32'h8000_0000;

  // Command codes on the cmd port
  localparam logic [1:0] CMD_WRITE_BITS = 2'd0;
  localparam logic [1:0] CMD_WRITE_INT  = 2'd1;
  localparam logic [1:0] CMD_READ_BYTE  = 2'd2;

  // Work kinds after classification
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_READ,
    KIND_UNIT,
    KIND_BITWISE
  } kind_t;

  // One classified word in the queue
  typedef struct packed {
    kind_t              kind;
    logic [COUNT_W-1:0] count;
    logic [31:0]        value;
    logic [BIDX_W-1:0]  byte_index;
  } lbp_item_t;

endpackage

`default_nettype wire

[rtl/core/lbp_front.sv]
// Front end of the bit packer: captures a command word and classifies it
// into a work kind and bit count. Depends on lbp_pkg.
`default_nettype none

module lbp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd,
  input  wire logic [31:0]       value,
  input  wire logic [5:0]        bit_count,
  input  wire logic [31:0]       maximum,
  input  wire logic [9:0]        byte_index,
  input  wire logic              q_full,
  output logic                   push,
  output lbp_pkg::lbp_item_t     item
);
  import lbp_pkg::*;

  logic        fv;
  logic [1:0]  cmd_q;
  logic [31:0] value_q;
  logic [5:0]  count_q;
  logic [31:0] max_q;
  logic [9:0]  bidx_q;
  logic [31:0] max_m1;
  logic        accept;

  // Bit length of a 32-bit word, found per byte then across bytes
  function automatic logic [5:0] bit_length(input logic [31:0] x);
    logic [3:0]      any;
    logic [3:0][2:0] hi;
    logic [5:0]      res;
    res = '0;
    for (int g = 0; g < 4; g++) begin
      any[g] = |x[g*8 +: 8];
      hi[g]  = '0;
      for (int j = 0; j < 8; j++) begin
        if (x[g*8 + j]) begin
          hi[g] = 3'(j);
        end
      end
    end
    for (int g = 0; g < 4; g++) begin
      if (any[g]) begin
        res = 6'({2'(g), hi[g]}) + 6'd1;
      end
    end
    return res;
  endfunction

  assign busy   = fv && q_full;
  assign push   = fv && !q_full;
  assign accept = start && !busy;

  // Hold the captured word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      value_q <= value;
      count_q <= bit_count;
      max_q   <= maximum;
      bidx_q  <= byte_index;
    end
  end

  assign max_m1 = max_q - 32'd1;

  // Classify the captured word
  always_comb begin
    item.value      = value_q;
    item.byte_index = bidx_q;
    item.kind       = KIND_NOP;
    item.count      = '0;
    case (cmd_q)
      CMD_WRITE_BITS: begin
        item.kind  = KIND_UNIT;
        item.count = (count_q > 6'd32) ? 6'd32 : count_q;
      end
      CMD_WRITE_INT: begin
        if (max_q <= 32'd1) begin
          item.kind  = KIND_UNIT;
          item.count = '0;
        end else if (max_q > FULL_WIDTH_BOUND) begin
          item.kind  = KIND_UNIT;
          item.count = 6'd32;
        end else begin
          item.kind  = KIND_BITWISE;
          item.count = bit_length(max_m1);
        end
      end
      CMD_READ_BYTE: begin
        item.kind = KIND_READ;
      end
      default: begin
        item.kind = KIND_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/lbp_queue.sv]
// Short word queue between the packer front and back ends.
// Depends on lbp_pkg for the item type and depth.
`default_nettype none

module lbp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire lbp_pkg::lbp_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output lbp_pkg::lbp_item_t      head,
  output logic                    empty
);
  import lbp_pkg::*;

  localparam int PtrW = (LBP_QUEUE_DEPTH > 1) ? $clog2(LBP_QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(LBP_QUEUE_DEPTH + 1);

  lbp_item_t           slots [LBP_QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     fill;

  assign full  = (fill == CntW'(LBP_QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(LBP_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(LBP_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lbp_back.sv]
// Back end of the bit packer: holds capacity, position and overflow flag,
// packs bits into the byte store one byte chunk a cycle, serves byte reads.
// Depends on lbp_pkg.
`default_nettype none

module lbp_back #(
  parameter int STORE_BYTES = lbp_pkg::LBP_STORE_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [13:0]        cfg_data,
  input  wire lbp_pkg::lbp_item_t head,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    done,
  output logic                    error,
  output logic [13:0]             bit_position,
  output logic [7:0]              read_data
);
  import lbp_pkg::*;

  localparam int StoreBits = STORE_BYTES * 8;
  localparam int LimCap    = (StoreBits > 16383) ? 16383 : StoreBits;
  localparam int AW        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int WideW     = (AW > POS_W - 3) ? AW : POS_W - 3;
  localparam int RdW       = (AW > BIDX_W) ? AW : BIDX_W;
  localparam logic [POS_W-1:0] LimMax = POS_W'(LimCap);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_RUN  = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  state_t             state;
  logic [POS_W-1:0]   capacity;
  logic [POS_W-1:0]   pos;
  logic               flag;
  logic [7:0]         acc;

  kind_t              kind;
  logic [COUNT_W-1:0] rem;
  logic [31:0]        shreg;
  logic [BIDX_W-1:0]  bidx;
  logic [7:0]         rdata;

  logic [7:0]         mem [STORE_BYTES];
  logic [7:0]         mem_rdata;
  logic               mem_we;
  logic [WideW-1:0]   waddr_wide;
  logic [RdW-1:0]     raddr_wide;

  logic [POS_W-1:0]   lim;
  logic [POS_W-1:0]   avail;
  logic               short_room;
  logic [COUNT_W-1:0] nwrite;

  logic [2:0]         off;
  logic [3:0]         room;
  logic [3:0]         take;
  logic [7:0]         low_mask;
  logic [7:0]         chunk;
  logic [7:0]         acc_new;
  logic               byte_full;
  logic [7:0]         read_sel;
  logic [POS_W-4:0]   cur_byte;

  assign pop          = (state == S_IDLE) && !empty;
  assign error        = flag;
  assign bit_position = pos;
  assign read_data    = rdata;

  // Room check against the smaller of capacity and store size
  always_comb begin
    lim        = (capacity < LimMax) ? capacity : LimMax;
    avail      = (pos <= lim) ? lim - pos : '0;
    short_room = POS_W'(rem) > avail;
    if (kind == KIND_BITWISE) begin
      nwrite = short_room ? COUNT_W'(avail) : rem;
    end else begin
      nwrite = short_room ? '0 : rem;
    end
  end

  // Merge up to one byte's worth of bits at the current offset
  always_comb begin
    off       = pos[2:0];
    room      = 4'd8 - {1'b0, off};
    take      = (rem < COUNT_W'(room)) ? rem[3:0] : room;
    low_mask  = 8'(9'h0FF >> (4'd8 - take));
    chunk     = shreg[7:0] & low_mask;
    acc_new   = acc | 8'(chunk << off);
    byte_full = ({1'b0, off} + take) == 4'd8;
  end

  // Bytes below the current one come from the store, the current one from
  // the assembly register, bytes ahead of the position were never written
  always_comb begin
    cur_byte = pos[POS_W-1:3];
    if (POS_W'({1'b0, bidx}) == POS_W'(cur_byte)) begin
      read_sel = acc;
    end else if (POS_W'({1'b0, bidx}) < POS_W'(cur_byte)) begin
      read_sel = mem_rdata;
    end else begin
      read_sel = '0;
    end
  end

  assign mem_we     = (state == S_RUN) && byte_full;
  assign waddr_wide = WideW'(pos[POS_W-1:3]);
  assign raddr_wide = RdW'(bidx);

  // Byte store: write full bytes, read at the requested index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr_wide[AW-1:0]] <= acc_new;
    end
    mem_rdata <= mem[raddr_wide[AW-1:0]];
  end

  // Control: sequencer, position, flag, assembly byte, capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      pos      <= '0;
      flag     <= 1'b0;
      acc      <= '0;
      capacity <= CAPACITY_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          case (kind)
            KIND_READ: begin
              state <= S_READ;
            end
            KIND_UNIT, KIND_BITWISE: begin
              if (short_room) begin
                flag <= 1'b1;
              end
              if (nwrite == '0) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_RUN;
              end
            end
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_RUN: begin
          pos <= pos + POS_W'(take);
          acc <= byte_full ? 8'd0 : acc_new;
          if (rem == COUNT_W'(take)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_READ: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Data path registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind  <= head.kind;
        rem   <= head.count;
        shreg <= head.value;
        bidx  <= head.byte_index;
      end
      S_PREP: begin
        rem   <= nwrite;
        rdata <= '0;
      end
      S_RUN: begin
        shreg <= shreg >> take;
        rem   <= rem - COUNT_W'(take);
        rdata <= '0;
      end
      S_READ: begin
        rdata <= read_sel;
      end
      default: begin
        rdata <= '0;
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= LimMax)
    else $error("write position beyond store or capacity range");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    flag |=> flag)
    else $error("overflow flag cleared without reset");

  a_run_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ((rem != '0) && (pos < LimMax)))
    else $error("packing with no bits left or no room");

endmodule

`default_nettype wire

[rtl/core/lsb_first_bit_packer.sv]
// LSB-first bit packer, top level: front end, word queue and back end.
// Depends on lbp_pkg, lbp_front, lbp_queue and lbp_back.
//
// A word is taken at a clock edge where start is high and busy is low; each
// word yields one result, shown for exactly one cycle with done high, and
// the receiver cannot hold it off. The front stage registers and classifies
// a word, and a two-entry queue lets it take the next word while the back
// end works. The back end fetches a word, checks room, then packs the field
// into each store byte it touches in turn (up to five for 32 bits); reads
// add a state for the registered store read, and zero-length writes,
// overflowing unit writes and no-ops finish after the room check. The back
// end takes no new word until it has finished the last one, and the store
// needs no clearing pass after reset: bytes beyond the one that holds the
// write position read as zero without touching the store.
`default_nettype none

module lsb_first_bit_packer #(
  parameter int STORE_BYTES = lbp_pkg::LBP_STORE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] value,
  input  wire logic [5:0]  bit_count,
  input  wire logic [31:0] maximum,
  input  wire logic [9:0]  byte_index,
  input  wire logic        cfg_write,
  input  wire logic [13:0] cfg_data,
  output logic             done,
  output logic             error,
  output logic [13:0]      bit_position,
  output logic [7:0]       read_data
);
  import lbp_pkg::*;

  lbp_item_t front_item;
  lbp_item_t q_head;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;

  lbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .value      (value),
    .bit_count  (bit_count),
    .maximum    (maximum),
    .byte_index (byte_index),
    .q_full     (q_full),
    .push       (q_push),
    .item       (front_item)
  );

  lbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  lbp_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (q_pop),
    .done         (done),
    .error        (error),
    .bit_position (bit_position),
    .read_data    (read_data)
  );

endmodule

`default_nettype wire
